// ===== sv/b64d_pkg.sv =====
`default_nettype none

package b64d_pkg;

  // default width of the per-string value counter
  localparam int COUNT_WIDTH_DEF = 24;

  // result kind codes
  localparam logic [1:0] KIND_DATA    = 2'd0;
  localparam logic [1:0] KIND_END     = 2'd1;
  localparam logic [1:0] KIND_ILLEGAL = 2'd2;

  localparam logic [6:0] CH_SPACE = 7'h20;
  localparam logic [6:0] CH_EQUAL = 7'h3d;
  localparam logic [6:0] CH_DEL   = 7'h7f;
  localparam logic [6:0] CH_PLUS  = 7'h2b;
  localparam logic [6:0] CH_SLASH = 7'h2f;
  localparam logic [6:0] CH_UC_A  = 7'h41;
  localparam logic [6:0] CH_UC_Z  = 7'h5a;
  localparam logic [6:0] CH_LC_A  = 7'h61;
  localparam logic [6:0] CH_LC_Z  = 7'h7a;
  localparam logic [6:0] CH_NUM_0 = 7'h30;
  localparam logic [6:0] CH_NUM_9 = 7'h39;

  typedef enum logic [1:0] {
    CLS_SKIP,
    CLS_DIGIT,
    CLS_ILLEGAL
  } char_cls_e_t;

  typedef struct packed {
    char_cls_e_t cls;
    logic [5:0]  digit;
  } char_class_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic [7:0] data;
  } result_info_t;

  // mime alphabet lookup on the low seven bits
  function automatic char_class_t classify(input logic [6:0] ch7);
    char_class_t c;
    logic [6:0]  d;
    c.cls   = CLS_ILLEGAL;
    c.digit = 6'd0;
    d       = 7'd0;
    if (ch7 < CH_SPACE || ch7 == CH_DEL || ch7 == CH_SPACE || ch7 == CH_EQUAL) begin
      c.cls = CLS_SKIP;
    end else if (ch7 >= CH_UC_A && ch7 <= CH_UC_Z) begin
      c.cls = CLS_DIGIT;
      d     = ch7 - CH_UC_A;
    end else if (ch7 >= CH_LC_A && ch7 <= CH_LC_Z) begin
      c.cls = CLS_DIGIT;
      d     = ch7 - CH_LC_A + 7'd26;
    end else if (ch7 >= CH_NUM_0 && ch7 <= CH_NUM_9) begin
      c.cls = CLS_DIGIT;
      d     = ch7 - CH_NUM_0 + 7'd52;
    end else if (ch7 == CH_PLUS) begin
      c.cls = CLS_DIGIT;
      d     = 7'd62;
    end else if (ch7 == CH_SLASH) begin
      c.cls = CLS_DIGIT;
      d     = 7'd63;
    end
    c.digit = d[5:0];
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== sv/b64d_class.sv =====
`default_nettype none

module b64d_class (
  input  wire logic [7:0]            char_in,
  output b64d_pkg::char_class_t      cls,
  output logic                       is_end
);
  import b64d_pkg::*;

  // parity bit dropped before lookup, only a true zero ends a string
  assign cls    = classify(char_in[6:0]);
  assign is_end = (char_in == 8'd0);

endmodule

`default_nettype wire

// ===== sv/b64d_accum.sv =====
`default_nettype none

module b64d_accum #(
  parameter int COUNT_WIDTH = b64d_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   step,
  input  wire logic                   is_end,
  input  wire b64d_pkg::char_class_t  cls,
  output b64d_pkg::result_info_t      res,
  output logic [COUNT_WIDTH-1:0]      res_count
);
  import b64d_pkg::*;

  logic [5:0]             buf_r, buf_nxt;
  logic [2:0]             bc_r, bc_nxt;
  logic                   halt_r, halt_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic [11:0]            acc;
  logic [11:0]            acc_sh;
  logic [11:0]            keep_mask;
  logic [2:0]             sh;

  assign acc       = {buf_r, cls.digit};
  assign sh        = bc_r - 3'd2;
  assign acc_sh    = acc >> sh;
  assign keep_mask = (12'd1 << sh) - 12'd1;

  always_comb begin
    buf_nxt   = buf_r;
    bc_nxt    = bc_r;
    halt_nxt  = halt_r;
    cnt_nxt   = cnt_r;
    res.valid = 1'b0;
    res.kind  = KIND_DATA;
    res.data  = 8'd0;
    res_count = cnt_r;
    if (is_end) begin
      res.valid = 1'b1;
      res.kind  = KIND_END;
      buf_nxt   = 6'd0;
      bc_nxt    = 3'd0;
      halt_nxt  = 1'b0;
      cnt_nxt   = '0;
    end else if (!halt_r) begin
      unique case (cls.cls)
        CLS_SKIP: begin
        end
        CLS_ILLEGAL: begin
          halt_nxt  = 1'b1;
          res.valid = 1'b1;
          res.kind  = KIND_ILLEGAL;
        end
        CLS_DIGIT: begin
          if (bc_r == 3'd0) begin
            buf_nxt = cls.digit;
            bc_nxt  = 3'd6;
          end else begin
            buf_nxt   = acc[5:0] & keep_mask[5:0];
            bc_nxt    = sh;
            res.valid = 1'b1;
            res.data  = acc_sh[7:0];
            if (cnt_r != '1) begin
              cnt_nxt = cnt_r + 1'b1;
            end
            res_count = cnt_nxt;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r  <= 6'd0;
      bc_r   <= 3'd0;
      halt_r <= 1'b0;
      cnt_r  <= '0;
    end else if (step) begin
      buf_r  <= buf_nxt;
      bc_r   <= bc_nxt;
      halt_r <= halt_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/base64_stream_decoder.sv =====
// channel | ports                                              | direction
// --------+----------------------------------------------------+----------
// input   | in_valid, in_stall, in_char_in                     | in
// result  | out_valid, out_stall, out_result_kind,             | out
//         | out_data_value, out_value_count                    |
//
// one character per cycle while the result side is not stalled; an input beat
// reaches the result beat through the input register and the result register
// the accumulator update sits between those two registers in a single pass
// reset (rst_n low, synchronous) empties both registers and clears the
// bit buffer, bit count, halt flag and value count
// a stalled result holds in the result register; the input register keeps
// taking beats while it is empty or the result slot is free or draining
`default_nettype none

module base64_stream_decoder #(
  parameter int COUNT_WIDTH = b64d_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [7:0]             in_char_in,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [1:0]                  out_result_kind,
  output logic [7:0]                  out_data_value,
  output logic [COUNT_WIDTH-1:0]      out_value_count
);
  import b64d_pkg::*;

  // input register
  logic       in_vld_r;
  logic [7:0] in_char_r;

  // result register
  logic                   out_vld_r;
  logic [1:0]             out_kind_r;
  logic [7:0]             out_data_r;
  logic [COUNT_WIDTH-1:0] out_count_r;

  logic                   advance;
  logic                   step;
  logic                   is_end;
  char_class_t            cls;
  result_info_t           res;
  logic [COUNT_WIDTH-1:0] res_count;

  // the held character moves on when the result slot is free or draining
  assign advance  = !out_vld_r || !out_stall;
  assign step     = in_vld_r && advance;
  assign in_stall = in_vld_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_char_r <= in_char_in;
    end
  end

  b64d_class u_class (
    .char_in (in_char_r),
    .cls     (cls),
    .is_end  (is_end)
  );

  b64d_accum #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .is_end    (is_end),
    .cls       (cls),
    .res       (res),
    .res_count (res_count)
  );

  // skipped characters and halted input leave the result slot empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= step && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.valid) begin
      out_kind_r  <= res.kind;
      out_data_r  <= res.data;
      out_count_r <= res_count;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_result_kind = out_kind_r;
  assign out_data_value  = out_data_r;
  assign out_value_count = out_count_r;

  // the input side only holds off while a character is actually waiting
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_vld_r)
    else $error("input stalled with empty input register");

  // an accepted beat always lands in the input register
  a_beat_captured: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_vld_r)
    else $error("accepted beat lost");

  // a zero character always produces an end beat in the next cycle
  a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    (step && in_char_r == 8'd0) |=> (out_vld_r && out_kind_r == KIND_END))
    else $error("end of string gave no end beat");

  // only data beats carry a nonzero value
  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_kind_r != KIND_DATA) |-> out_data_r == 8'd0)
    else $error("non-data beat carries a value");

endmodule

`default_nettype wire
